// ----- design/rsch_pkg.sv -----
// Shared types, constants and arithmetic helpers for the square closest-hit block.
`default_nettype none
package rsch_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int FRAC_DEFAULT  = 16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RAY  = 1'b1;

    // Payload of one input transaction.
    typedef struct packed {
        logic               opcode;
        logic        [3:0]  slot;
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_z;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_z;
        logic        [30:0] side_length;
        logic        [23:0] surface_colour;
    } ray_req_t;

    // Payload of one result transaction.
    typedef struct packed {
        logic               hit;
        logic        [3:0]  hit_slot;
        logic        [30:0] hit_distance;
        logic        [23:0] hit_colour;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } hit_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write one table slot from the input transaction
        logic ray_start;  // latch the ray and clear the best hit
        logic slot_rd;    // issue a table read for the scan slot
        logic dot_mul;    // form the d vector and products
        logic dot_sum;    // sum products into a and b
        logic div_start;  // start the divider
        logic bnd_mul;    // direction times t products
        logic bnd_chk;    // bounds compare and best update
        logic finish;     // build the result
    } rsch_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic b_zero;
        logic div_done;
    } rsch_sts_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        begin
            if (x > 64'sh0000_0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (x < -64'sh0000_0000_8000_0000)
                r = 32'sh8000_0000;
            else
                r = x[31:0];
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/rsch_if.sv -----
// Valid/ready channel interface carrying a payload of a given type.
`default_nettype none
interface rsch_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/rsch_div.sv -----
// Radix-2 restoring divider for signed 64-by-32 quotients, one bit a cycle.
`default_nettype none
module rsch_div import rsch_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [63:0]      quo
);
    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    // Shift one quotient bit a cycle.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {r_reg[31:0], q_reg[63]};
        trial = {1'b0, shifted} - {2'b00, d_reg};
        if (start)
        begin
            q_next = num[63] ? 64'(-num) : num;
            d_next = den[31] ? 32'(-den) : den;
            neg_next = num[63] ^ den[31];
            r_next = '0;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_next = trial[32:0];
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    // Done is raised in the same cycle that the last quotient bit appears in the quotient register.
    assign done = done_reg;
    assign quo  = neg_reg ? 64'(-q_reg) : q_reg;
endmodule
`default_nettype wire

// ----- design/rsch_datapath.sv -----
// Table storage, dot products, bounds test and best-hit tracking.
`default_nettype none
module rsch_datapath import rsch_pkg::*; #(
    parameter int SQUARE_SLOTS = SLOTS_DEFAULT,
    parameter int FRAC_BITS    = FRAC_DEFAULT,
    parameter int SW           = (SQUARE_SLOTS > 1) ? $clog2(SQUARE_SLOTS) : 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rsch_cmd_t          cmd,
    input  wire logic [SW-1:0]      scan_slot,
    input  wire logic [3:0]         in_slot,
    input  wire logic signed [31:0] in_first [3],
    input  wire logic signed [31:0] in_second [3],
    input  wire logic [30:0]        in_width,
    input  wire logic [23:0]        in_colour,
    output rsch_sts_t               sts,
    output logic                    res_hit,
    output logic [3:0]              res_slot,
    output logic [30:0]             res_dist,
    output logic [23:0]             res_colour,
    output logic signed [31:0]      res_normal [3],
    output logic signed [31:0]      res_point [3]
);
    logic signed [31:0] cen_mem [SQUARE_SLOTS][3];
    logic signed [31:0] nrm_mem [SQUARE_SLOTS][3];
    logic [30:0]        wid_mem [SQUARE_SLOTS];
    logic [23:0]        col_mem [SQUARE_SLOTS];

    logic signed [31:0] org_reg [3];
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] cen_reg [3];
    logic signed [31:0] nrm_reg [3];
    logic [30:0]        wid_reg;
    logic [SW-1:0]      cur_reg;
    logic signed [63:0] pa_reg [3];
    logic signed [63:0] pb_reg [3];
    logic signed [31:0] a_reg, b_reg;
    logic signed [31:0] t_reg;
    logic signed [63:0] pt_reg [3];
    logic               found_reg;
    logic               pos_reg;
    logic signed [31:0] best_t_reg;
    logic [SW-1:0]      best_slot_reg;
    logic signed [31:0] best_pt_reg [3];
    logic               div_done;
    logic signed [63:0] quo;
    logic signed [63:0] sa, sb;
    logic signed [31:0] dsat [3];
    logic               in_bounds;
    logic signed [63:0] e [3];
    logic signed [63:0] ea [3];
    logic signed [31:0] hp [3];

    rsch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (-(64'(signed'(a_reg)) <<< FRAC_BITS)),
        .den   (b_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // Table write on a load and registered read during the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.load && (32'(in_slot) < SQUARE_SLOTS))
        begin
            cen_mem[SW'(in_slot)] <= in_first;
            nrm_mem[SW'(in_slot)] <= in_second;
            wid_mem[SW'(in_slot)] <= in_width;
            col_mem[SW'(in_slot)] <= in_colour;
        end
        if (cmd.slot_rd)
        begin
            cen_reg <= cen_mem[scan_slot];
            nrm_reg <= nrm_mem[scan_slot];
            wid_reg <= wid_mem[scan_slot];
            cur_reg <= scan_slot;
        end
    end

    // Per-axis offsets saturated, bounds offsets held exactly, and hit points saturated.
    always_comb
    begin
        in_bounds = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            dsat[i] = sat32(64'(org_reg[i]) - 64'(cen_reg[i]));
            e[i] = (pt_reg[i] >>> FRAC_BITS) + 64'(org_reg[i]) - 64'(cen_reg[i]);
            ea[i] = e[i][63] ? -e[i] : e[i];
            if ((ea[i] <<< 1) > $signed({33'd0, wid_reg}))
                in_bounds = 1'b0;
            hp[i] = sat32(64'(org_reg[i]) + (pt_reg[i] >>> FRAC_BITS));
        end
        sa = (pa_reg[0] >>> FRAC_BITS) + (pa_reg[1] >>> FRAC_BITS)
           + (pa_reg[2] >>> FRAC_BITS);
        sb = (pb_reg[0] >>> FRAC_BITS) + (pb_reg[1] >>> FRAC_BITS)
           + (pb_reg[2] >>> FRAC_BITS);
    end

    // Arithmetic pipeline registers.
    always_ff @(posedge clk)
    begin
        if (cmd.ray_start)
        begin
            org_reg <= in_first;
            dir_reg <= in_second;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.dot_mul)
            begin
                pa_reg[i] <= 64'(dsat[i]) * 64'(nrm_reg[i]);
                pb_reg[i] <= 64'(dir_reg[i]) * 64'(nrm_reg[i]);
            end
            if (cmd.bnd_mul)
                pt_reg[i] <= 64'(dir_reg[i]) * 64'(t_reg);
        end
        if (cmd.dot_sum)
        begin
            a_reg <= sat32(sa);
            b_reg <= sat32(sb);
        end
        if (div_done)
        begin
            pos_reg <= (quo > 64'sd0);
            t_reg <= (quo > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
        end
    end

    // Best hit so far; strict compare keeps the lower slot on ties.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else if (cmd.ray_start)
            found_reg <= 1'b0;
        else if (cmd.bnd_chk && pos_reg && in_bounds && (!found_reg || t_reg < best_t_reg))
            found_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bnd_chk && pos_reg && in_bounds && (!found_reg || t_reg < best_t_reg))
        begin
            best_t_reg <= t_reg;
            best_slot_reg <= cur_reg;
            best_pt_reg <= hp;
        end
    end

    // Result register, cleared when there is no hit.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_hit    <= found_reg;
            res_slot   <= found_reg ? 4'(best_slot_reg) : 4'd0;
            res_dist   <= found_reg ? best_t_reg[30:0] : 31'd0;
            res_colour <= found_reg ? col_mem[best_slot_reg] : 24'd0;
            for (int i = 0; i < 3; i++)
            begin
                res_normal[i] <= found_reg ? nrm_mem[best_slot_reg][i] : 32'sd0;
                res_point[i]  <= found_reg ? best_pt_reg[i] : 32'sd0;
            end
        end
    end

    assign sts.b_zero   = (b_reg == 32'sd0);
    assign sts.div_done = div_done;
endmodule
`default_nettype wire

// ----- design/rsch_ctrl.sv -----
// Controller state machine: sequences loads, the slot scan and result hand-off.
`default_nettype none
module rsch_ctrl import rsch_pkg::*; #(
    parameter int SQUARE_SLOTS = SLOTS_DEFAULT,
    parameter int SW           = (SQUARE_SLOTS > 1) ? $clog2(SQUARE_SLOTS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_op,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire logic [4:0]    count,
    input  wire rsch_sts_t     sts,
    output rsch_cmd_t          cmd,
    output logic [SW-1:0]      scan_slot
);
    localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_MUL = 4'd2, S_SUM = 4'd3,
                           S_DIV = 4'd4, S_WAIT = 4'd5, S_BMUL = 4'd6, S_BCHK = 4'd7,
                           S_NEXT = 4'd8, S_FIN = 4'd9;
    localparam int CW = $clog2(SQUARE_SLOTS + 1);

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] lim;
    logic          outv_reg, outv_next;
    logic          take;

    assign lim = (32'(count) > SQUARE_SLOTS) ? CW'(SQUARE_SLOTS) : CW'(count);
    assign in_ready = (state_reg == S_IDLE);
    assign take = in_valid && in_ready;
    assign out_valid = outv_reg;
    assign scan_slot = idx_reg[SW-1:0];

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        outv_next = outv_reg;
        cmd = '0;
        if (outv_reg && out_ready)
            outv_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (in_op == OP_LOAD)
                        cmd.load = 1'b1;
                    else
                    begin
                        cmd.ray_start = 1'b1;
                        idx_next = '0;
                        state_next = S_NEXT;
                    end
                end
            end
            S_NEXT:
                state_next = (idx_reg < lim) ? S_READ : S_FIN;
            S_READ:
            begin
                cmd.slot_rd = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.dot_mul = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.dot_sum = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.b_zero)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
                if (sts.div_done)
                    state_next = S_BMUL;
            S_BMUL:
            begin
                cmd.bnd_mul = 1'b1;
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                cmd.bnd_chk = 1'b1;
                idx_next = idx_reg + 1'b1;
                state_next = S_NEXT;
            end
            S_FIN:
            begin
                // Hold the new result until the output register is free or leaving.
                if (!outv_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    outv_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            outv_reg  <= outv_next;
        end
    end
endmodule
`default_nettype wire

// ----- design/ray_square_closest_hit.sv -----
// Top level: nearest-square ray intersection with a loadable square table.
// Sequence: a load is taken from idle; per scanned slot a ray runs read, multiply, sum
// and, unless b is zero, the 64-step divider, bounds multiply and check; then the result.
// Throughput: one ray at a time; a new transaction is taken while the result waits, and a
// finished ray holds its result until the previous one has been accepted.
// Reset: rst_n clears the controller, count_reg and the output valid; the table reads
// undefined until loaded.
`default_nettype none
module ray_square_closest_hit import rsch_pkg::*; #(
    parameter int SQUARE_SLOTS = SLOTS_DEFAULT,
    parameter int FRAC_BITS    = FRAC_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [4:0] cfg_wdata,
    rsch_if.sink       in_ch,
    rsch_if.source     out_ch
);
    localparam int SW = (SQUARE_SLOTS > 1) ? $clog2(SQUARE_SLOTS) : 1;

    logic [4:0]         count_reg;
    rsch_cmd_t          cmd;
    rsch_sts_t          sts;
    logic [SW-1:0]      scan_slot;
    logic signed [31:0] first_v [3];
    logic signed [31:0] second_v [3];
    logic signed [31:0] nrm_o [3];
    logic signed [31:0] pt_o [3];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg_we)
            count_reg <= cfg_wdata;
    end

    assign first_v  = '{in_ch.data.first_x, in_ch.data.first_y, in_ch.data.first_z};
    assign second_v = '{in_ch.data.second_x, in_ch.data.second_y, in_ch.data.second_z};

    rsch_ctrl #(.SQUARE_SLOTS(SQUARE_SLOTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.data.opcode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .count     (count_reg),
        .sts       (sts),
        .cmd       (cmd),
        .scan_slot (scan_slot)
    );

    rsch_datapath #(.SQUARE_SLOTS(SQUARE_SLOTS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .scan_slot  (scan_slot),
        .in_slot    (in_ch.data.slot),
        .in_first   (first_v),
        .in_second  (second_v),
        .in_width   (in_ch.data.side_length),
        .in_colour  (in_ch.data.surface_colour),
        .sts        (sts),
        .res_hit    (out_ch.data.hit),
        .res_slot   (out_ch.data.hit_slot),
        .res_dist   (out_ch.data.hit_distance),
        .res_colour (out_ch.data.hit_colour),
        .res_normal (nrm_o),
        .res_point  (pt_o)
    );

    assign out_ch.data.normal_x = nrm_o[0];
    assign out_ch.data.normal_y = nrm_o[1];
    assign out_ch.data.normal_z = nrm_o[2];
    assign out_ch.data.point_x  = pt_o[0];
    assign out_ch.data.point_y  = pt_o[1];
    assign out_ch.data.point_z  = pt_o[2];

    // A result with no hit carries zero distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.data.hit |-> out_ch.data.hit_distance == 31'd0)
        else $error("no-hit result has nonzero distance");

    // A hit always has positive distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.hit |-> out_ch.data.hit_distance != 31'd0)
        else $error("hit with zero distance");

    // Only one datapath step is commanded in a cycle.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("conflicting datapath commands");
endmodule
`default_nettype wire

// ----- tb/tb_ray_square_closest_hit.sv -----
// Self-checking testbench for the nearest-square ray intersection block.
module tb_ray_square_closest_hit;
    import rsch_pkg::*;

    localparam longint ONE        = 65536;
    localparam int     NUM_SLOTS  = 16;
    localparam longint CYCLE_CAP  = 5000000;
    localparam int     RAND_ITEMS = 88;

    typedef enum logic { ROW_CONFIG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [4:0] count;
        ray_req_t  req;
        bit        typed;
        hit_rsp_t  want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;

    rsch_if #(.payload_t(ray_req_t)) in_ch ();
    rsch_if #(.payload_t(hit_rsp_t)) out_ch ();

    ray_square_closest_hit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copy of the square table and the slot count.
    longint sq_cx [NUM_SLOTS];
    longint sq_cy [NUM_SLOTS];
    longint sq_cz [NUM_SLOTS];
    longint sq_nx [NUM_SLOTS];
    longint sq_ny [NUM_SLOTS];
    longint sq_nz [NUM_SLOTS];
    longint sq_w  [NUM_SLOTS];
    longint sq_col[NUM_SLOTS];
    int     scan_count;

    hit_rsp_t  hit_expect_q[$];
    stim_row_t directed_rows[$];

    int     mismatches;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     hold_left;
    int     loads_sent;
    int     rays_sent;
    int     results_seen;
    int     hits_seen;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
                 results_seen);
    endtask

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Fixed-point dot product: each product floored, then the sum saturated.
    function automatic longint fx_dot(input longint p0, input longint p1, input longint p2,
                                      input longint q0, input longint q1, input longint q2);
        return clip32(((p0 * q0) >>> 16) + ((p1 * q1) >>> 16) + ((p2 * q2) >>> 16));
    endfunction

    // Writes one square into the shadow table.
    function automatic void store_square(input ray_req_t r);
        sq_cx[r.slot]  = longint'(r.first_x);
        sq_cy[r.slot]  = longint'(r.first_y);
        sq_cz[r.slot]  = longint'(r.first_z);
        sq_nx[r.slot]  = longint'(r.second_x);
        sq_ny[r.slot]  = longint'(r.second_y);
        sq_nz[r.slot]  = longint'(r.second_z);
        sq_w[r.slot]   = longint'(r.side_length);
        sq_col[r.slot] = longint'(r.surface_colour);
    endfunction

    // Scans the table for the nearest square hit by the ray.
    function automatic hit_rsp_t trace_ray(input ray_req_t r);
        hit_rsp_t e;
        longint   org[3];
        longint   dir[3];
        longint   cen[3];
        longint   a;
        longint   b;
        longint   t;
        longint   ex;
        longint   best_t;
        int       best;
        int       n;
        bit       found;
        bit       in_bounds;
        e      = '0;
        found  = 0;
        best   = 0;
        best_t = 0;
        org[0] = longint'(r.first_x);
        org[1] = longint'(r.first_y);
        org[2] = longint'(r.first_z);
        dir[0] = longint'(r.second_x);
        dir[1] = longint'(r.second_y);
        dir[2] = longint'(r.second_z);
        n = (scan_count > NUM_SLOTS) ? NUM_SLOTS : scan_count;
        for (int s = 0; s < n; s++)
        begin
            cen[0] = sq_cx[s];
            cen[1] = sq_cy[s];
            cen[2] = sq_cz[s];
            a = fx_dot(clip32(org[0] - cen[0]), clip32(org[1] - cen[1]),
                       clip32(org[2] - cen[2]), sq_nx[s], sq_ny[s], sq_nz[s]);
            b = fx_dot(dir[0], dir[1], dir[2], sq_nx[s], sq_ny[s], sq_nz[s]);
            if (b == 0)
                continue;
            t = (-a * ONE) / b;
            if (t <= 0)
                continue;
            if (t > 64'sd2147483647)
                t = 64'sd2147483647;
            in_bounds = 1;
            for (int j = 0; j < 3; j++)
            begin
                ex = ((dir[j] * t) >>> 16) + org[j] - cen[j];
                if (ex < 0)
                    ex = -ex;
                if (2 * ex > sq_w[s])
                    in_bounds = 0;
            end
            if (in_bounds && (!found || t < best_t))
            begin
                found  = 1;
                best_t = t;
                best   = s;
            end
        end
        if (found)
        begin
            e.hit          = 1'b1;
            e.hit_slot     = best[3:0];
            e.hit_distance = best_t[30:0];
            e.hit_colour   = sq_col[best][23:0];
            e.normal_x     = sq_nx[best][31:0];
            e.normal_y     = sq_ny[best][31:0];
            e.normal_z     = sq_nz[best][31:0];
            e.point_x      = 32'(clip32(org[0] + ((dir[0] * best_t) >>> 16)));
            e.point_y      = 32'(clip32(org[1] + ((dir[1] * best_t) >>> 16)));
            e.point_z      = 32'(clip32(org[2] + ((dir[2] * best_t) >>> 16)));
        end
        return e;
    endfunction

    function automatic ray_req_t make_load(input int s, input longint cx, input longint cy,
                                           input longint cz, input longint nx,
                                           input longint ny, input longint nz,
                                           input longint w, input longint col);
        ray_req_t r;
        r.opcode         = OP_LOAD;
        r.slot           = s[3:0];
        r.first_x        = 32'(clip32(cx));
        r.first_y        = 32'(clip32(cy));
        r.first_z        = 32'(clip32(cz));
        r.second_x       = 32'(clip32(nx));
        r.second_y       = 32'(clip32(ny));
        r.second_z       = 32'(clip32(nz));
        r.side_length    = w[30:0];
        r.surface_colour = col[23:0];
        return r;
    endfunction

    function automatic ray_req_t make_ray(input longint ox, input longint oy, input longint oz,
                                          input longint dx, input longint dy, input longint dz);
        ray_req_t r;
        r = make_load(0, ox, oy, oz, dx, dy, dz, 0, 0);
        r.opcode         = OP_RAY;
        r.slot           = 4'($urandom);
        r.side_length    = 31'($urandom);
        r.surface_colour = 24'($urandom);
        return r;
    endfunction

    function automatic ray_req_t noise_item(input logic op);
        ray_req_t     r;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(ray_req_t)-1:0];
        r.opcode = op;
        return r;
    endfunction

    function automatic longint signed_rand(input longint span);
        return longint'($urandom_range(32'(2 * span))) - span;
    endfunction

    // A square facing along one axis, at modest coordinates.
    function automatic ray_req_t square_item();
        longint n[3];
        int     ax;
        ax = $urandom_range(2);
        n  = '{0, 0, 0};
        n[ax] = $urandom_range(1) ? ONE : -ONE;
        return make_load($urandom_range(15), signed_rand(256 * ONE), signed_rand(256 * ONE),
                         signed_rand(256 * ONE), n[0], n[1], n[2],
                         longint'($urandom_range(32'(64 * ONE), 32'(ONE / 4))),
                         longint'($urandom));
    endfunction

    // A ray aimed from in front of a square in use, roughly back along its normal.
    function automatic ray_req_t aimed_ray();
        longint o[3];
        longint d[3];
        longint nv[3];
        longint cv[3];
        longint standoff;
        longint k;
        int     s;
        s        = $urandom_range((scan_count > 1) ?
                                  ((scan_count > 16) ? 15 : scan_count - 1) : 0);
        nv       = '{sq_nx[s], sq_ny[s], sq_nz[s]};
        cv       = '{sq_cx[s], sq_cy[s], sq_cz[s]};
        standoff = longint'($urandom_range(32'(200 * ONE), 32'(ONE / 8)));
        k        = longint'($urandom_range(32'(4 * ONE), 32'(ONE / 4)));
        for (int j = 0; j < 3; j++)
        begin
            o[j] = cv[j] + ((nv[j] * standoff) >>> 16)
                 + signed_rand(sq_w[s] > 0 ? sq_w[s] : 1);
            d[j] = -((nv[j] * k) >>> 16) + signed_rand(ONE / 4);
        end
        return make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endfunction

    // Offers one transaction and waits for its acceptance.
    task automatic send_item(input ray_req_t r, input bit typed, input hit_rsp_t want);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= r;
        do @(posedge clk); while (!in_ch.ready);
        if (r.opcode == OP_LOAD)
        begin
            store_square(r);
            loads_sent++;
        end
        else
        begin
            hit_expect_q.push_back(typed ? want : trace_ray(r));
            rays_sent++;
        end
    endtask

    // Lets every outstanding result arrive and the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (hit_expect_q.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_count(input logic [4:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        scan_count = int'(v);
    endtask

    task automatic add_row(input row_kind_t k, input logic [4:0] c, input ray_req_t r,
                           input bit typed, input hit_rsp_t want);
        stim_row_t row;
        row.kind  = k;
        row.count = c;
        row.req   = r;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Directed rows: empty table, ties, misses, extremes of fields and of the count.
    task automatic build_directed();
        hit_rsp_t none;
        hit_rsp_t front;
        none  = '0;
        front = '0;
        front.hit          = 1'b1;
        front.hit_slot     = 4'd0;
        front.hit_distance = 31'(5 * ONE);
        front.hit_colour   = 24'hFF0000;
        front.normal_z     = 32'(ONE);
        add_row(ROW_ITEM, 5'd0, make_ray(32'h7FFFFFFF, -64'sd2147483648, 32'h7FFFFFFF,
                -64'sd2147483648, 32'h7FFFFFFF, -64'sd2147483648), 1, none);
        add_row(ROW_ITEM, 5'd0, make_load(0, 0, 0, 0, 0, 0, ONE, 2 * ONE, 24'hFF0000), 0,
                none);
        add_row(ROW_ITEM, 5'd0, make_load(1, 0, 0, 0, 0, 0, ONE, 2 * ONE, 24'h00FF00), 0,
                none);
        add_row(ROW_ITEM, 5'd0, make_load(2, 0, 0, -4 * ONE, 0, 0, ONE, 31'h7FFFFFFF,
                24'hFFFFFF), 0, none);
        add_row(ROW_ITEM, 5'd0, make_load(3, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(ROW_ITEM, 5'd0, make_load(4, 0, 0, 0, 0, 0, ONE / 2, 2 * ONE, 24'h123456), 0,
                none);
        for (int s = 5; s < NUM_SLOTS; s++)
            add_row(ROW_ITEM, 5'd0, make_load(s, 1000 * ONE, 1000 * ONE, 1000 * ONE, ONE, 0,
                    0, ONE, s), 0, none);
        add_row(ROW_CONFIG, 5'd2, '0, 0, none);
        add_row(ROW_ITEM, 5'd0, make_ray(0, 0, 5 * ONE, 0, 0, -ONE), 1, front);
        add_row(ROW_CONFIG, 5'd16, '0, 0, none);
        add_row(ROW_ITEM, 5'd0, make_ray(0, 0, 5 * ONE, 0, 0, -ONE), 1, front);
        add_row(ROW_ITEM, 5'd0, make_ray(3 * ONE / 2, 0, 5 * ONE, 0, 0, -ONE), 0, none);
        add_row(ROW_ITEM, 5'd0, make_ray(0, 0, 5 * ONE, 0, 0, ONE), 1, none);
        add_row(ROW_ITEM, 5'd0, make_ray(0, 0, 5 * ONE, 1, 1, 1), 0, none);
        add_row(ROW_CONFIG, 5'd31, '0, 0, none);
        add_row(ROW_ITEM, 5'd0, make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                -64'sd2147483648, -64'sd2147483648, -64'sd2147483648), 0, none);
        add_row(ROW_ITEM, 5'd0, make_ray(0, 0, 64'sd2147483647, 0, 0, -1), 0, none);
    endtask

    // Stimulus: directed rows, then random phases over the idling modes.
    initial
    begin
        logic [4:0] phase_count [8];
        bit         is_load;
        phase_count = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd16, 5'd12, 5'd17, 5'd16};
        rst_n          = 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.data    <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        scan_count     = 0;
        mismatches     = 0;
        loads_sent     = 0;
        rays_sent      = 0;
        for (int s = 0; s < NUM_SLOTS; s++)
            store_square(make_load(s, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                set_count(directed_rows[i].count);
            else
                send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            set_count(phase_count[ph]);
            unique case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            // Long receiver hold-off so the block backs up onto its input.
            if (ph == 2)
                hold_left = 3000;
            for (int i = 0; i < RAND_ITEMS; i++)
            begin
                if (ph == 5 && i == RAND_ITEMS / 2)
                    drain();
                is_load = ($urandom_range(99) < 30);
                if (is_load)
                    send_item(($urandom_range(3) == 0) ? noise_item(OP_LOAD) : square_item(),
                              0, '0);
                else
                    send_item(($urandom_range(4) == 0) ? noise_item(OP_RAY) : aimed_ray(),
                              0, '0);
            end
        end

        drain();
        repeat (100) @(posedge clk);
        $display("Covered %0d loads and %0d rays; %0d results checked, %0d of them hits.",
                 loads_sent, rays_sent, results_seen, hits_seen);
        $display("Counts ran from 0 to 31 under four idling modes with a long output stall.");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, or a held-off stretch when one is requested.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        hit_rsp_t got;
        hit_rsp_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            results_seen++;
            if (got.hit)
                hits_seen++;
            if (hit_expect_q.size() == 0)
                report_mismatch("unexpected result", got.hit, 0);
            else
            begin
                want = hit_expect_q.pop_front();
                if (got.hit != want.hit)
                    report_mismatch("hit", got.hit, want.hit);
                if (got.hit_slot != want.hit_slot)
                    report_mismatch("hit_slot", got.hit_slot, want.hit_slot);
                if (got.hit_distance != want.hit_distance)
                    report_mismatch("hit_distance", got.hit_distance, want.hit_distance);
                if (got.hit_colour != want.hit_colour)
                    report_mismatch("hit_colour", got.hit_colour, want.hit_colour);
                if (got.normal_x != want.normal_x)
                    report_mismatch("normal_x", got.normal_x, want.normal_x);
                if (got.normal_y != want.normal_y)
                    report_mismatch("normal_y", got.normal_y, want.normal_y);
                if (got.normal_z != want.normal_z)
                    report_mismatch("normal_z", got.normal_z, want.normal_z);
                if (got.point_x != want.point_x)
                    report_mismatch("point_x", got.point_x, want.point_x);
                if (got.point_y != want.point_y)
                    report_mismatch("point_y", got.point_y, want.point_y);
                if (got.point_z != want.point_z)
                    report_mismatch("point_z", got.point_z, want.point_z);
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycles       = 0;
        results_seen = 0;
        hits_seen    = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
                         hit_expect_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

// ----- ray_square_closest_hit.f -----
design/rsch_pkg.sv
design/rsch_if.sv
design/rsch_div.sv
design/rsch_datapath.sv
design/rsch_ctrl.sv
design/ray_square_closest_hit.sv
tb/tb_ray_square_closest_hit.sv
